[design/wma_pkg.sv]
// Package for the weighted moments accumulator.
// Holds field widths, item kind and status codes and fixed point limits.
// No dependencies.
package wma_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int TOTAL_BITS  = 48;
	localparam int ACC_BITS    = 64;
	localparam int DIVA_BITS   = 128;
	localparam int MEAN_BITS   = 24;
	localparam int VAR_BITS    = 40;
	localparam int ROOT_BITS   = 24;

	localparam logic [1:0] K_CLEAR  = 2'd0;
	localparam logic [1:0] K_SAMPLE = 2'd1;
	localparam logic [1:0] K_REPORT = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_ONE   = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;
endpackage

[design/wma_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// 128-bit dividend by 64-bit divisor; uses wma_pkg.
module wma_div import wma_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIVA_BITS-1:0] dividend,
	input  logic [ACC_BITS-1:0]  divisor,
	output logic                 done,
	output logic [DIVA_BITS-1:0] quotient
);
	logic [DIVA_BITS-1:0] a_q;
	logic [DIVA_BITS-1:0] q_q;
	logic [ACC_BITS-1:0]  d_q;
	logic [ACC_BITS-1:0]  rem_q;
	logic [7:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ACC_BITS-1:0]  r;
	logic                 take;

	assign r    = {rem_q[ACC_BITS-2:0], a_q[DIVA_BITS-1]};
	assign take = rem_q[ACC_BITS-1] || (r >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				a_q    <= dividend;
				d_q    <= divisor;
				rem_q  <= '0;
				q_q    <= '0;
			end else if (busy_q) begin
				rem_q <= take ? (r - d_q) : r;
				q_q   <= {q_q[DIVA_BITS-2:0], take};
				a_q   <= {a_q[DIVA_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == 8'(DIVA_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule

[design/weighted_moments_accumulator_core.sv]
// Weighted mean, variance, min and max accumulator, top level.
// Uses wma_pkg and the iterative divider wma_div.
//
// channel  dir  tdata                              tuser
// s_*      in   sample[15:0] weight[31:16]         kind[1:0]
// m_*      out  total,min,max,mean,var,sd,se       status[1:0]
//
// Clear and ignored kinds end in IDLE; a sample uses the shared multiplier, then S_ACC.
// A report runs up to four 128-step divides and two 32-step square roots.
// s_tready is high only while idle; a finished report waits in the output register.
// Reset clears the accumulators and the output valid.
module weighted_moments_accumulator_core import wma_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // sample[15:0], weight[31:16]
	input  logic [1:0]   s_tuser,   // kind[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// total_weight[47:0], minimum[63:48], maximum[79:64], mean[103:80],
	// variance[143:104], std_dev[167:144], std_err[191:168]
	output logic [191:0] m_tdata,
	output logic [1:0]   m_tuser    // status[1:0]
);
	typedef enum logic [3:0] {
		IDLE, S_XW, S_XX, S_XXW, S_ACC, R_MEAN, R_MUL, R_CDIV, R_VDIV, R_SD, R_EDIV,
		R_SE, DONE
	} state_t;

	state_t state_q;
	logic [TOTAL_BITS-1:0]  tot_q;
	logic [ACC_BITS-1:0]    sum_q;
	logic [ACC_BITS-1:0]    sq_q;
	logic [SAMPLE_BITS-1:0] min_q, max_q;
	logic                   sat_q;
	logic [SAMPLE_BITS-1:0] x_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [32:0]            p_q;
	logic [31:0]            xx_q;
	logic [47:0]            p2_q;
	logic [1:0]             k_q;
	logic [DIVA_BITS-1:0]   acc_q;
	logic [MEAN_BITS-1:0]   mean_q;
	logic [VAR_BITS-1:0]    var_q;
	logic [ROOT_BITS-1:0]   sd_q, se_q;
	logic [ACC_BITS-1:0]    sqv_q, sqres_q, sqbit_q;
	logic                   div_start_q;
	logic [DIVA_BITS-1:0]   div_a_q;
	logic [ACC_BITS-1:0]    div_d_q;
	logic                   div_done;
	logic [DIVA_BITS-1:0]   div_q;
	logic                   m_tvalid_q;
	logic [191:0]           m_tdata_q;
	logic [1:0]             m_tuser_q;

	logic signed [32:0]     ma, mb;
	logic signed [65:0]     prod;
	logic                   neg;
	logic [ACC_BITS-1:0]    mag;
	logic [31:0]            half_a, half_b;
	logic [DIVA_BITS-1:0]   acc_nx;
	logic [65:0]            s66;
	logic [64:0]            t65;
	logic [TOTAL_BITS:0]    t49;
	logic [ACC_BITS-1:0]    sqt;
	logic                   sqge;
	logic [ACC_BITS-1:0]    sqres_nx;
	logic [MEAN_BITS-1:0]   mlim, m;
	logic [ACC_BITS-1:0]    dev;
	logic [VAR_BITS-1:0]    var_nx;
	logic [ROOT_BITS-1:0]   root_nx;
	logic [1:0]             status;
	logic [SAMPLE_BITS-1:0] sx;

	wma_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(div_a_q),
		.divisor(div_d_q), .done(div_done), .quotient(div_q)
	);

	assign sx     = s_tdata[SAMPLE_BITS-1:0];
	assign neg    = sum_q[ACC_BITS-1];
	assign mag    = neg ? (ACC_BITS'(0) - sum_q) : sum_q;
	assign half_a = k_q[1] ? mag[63:32] : mag[31:0];
	assign half_b = k_q[0] ? mag[63:32] : mag[31:0];

	always_comb begin
		unique case (state_q)
			S_XW: begin
				ma = 33'(signed'(x_q));
				mb = {17'd0, w_q};
			end
			S_XX: begin
				ma = 33'(signed'(x_q));
				mb = 33'(signed'(x_q));
			end
			S_XXW: begin
				ma = {1'b0, xx_q};
				mb = {17'd0, w_q};
			end
			R_MUL: begin
				ma = {1'b0, half_a};
				mb = {1'b0, half_b};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign prod = ma * mb;

	always_comb begin
		case ({1'b0, k_q[1]} + {1'b0, k_q[0]})
			2'd0:    acc_nx = acc_q + {64'd0, prod[63:0]};
			2'd1:    acc_nx = acc_q + {32'd0, prod[63:0], 32'd0};
			default: acc_nx = acc_q + {prod[63:0], 64'd0};
		endcase
	end

	assign s66 = {{2{sum_q[63]}}, sum_q} + {{33{p_q[32]}}, p_q};
	assign t65 = {1'b0, sq_q} + {17'd0, p2_q};
	assign t49 = {1'b0, tot_q} + {33'd0, w_q};

	assign sqt      = sqres_q + sqbit_q;
	assign sqge     = sqv_q >= sqt;
	assign sqres_nx = sqge ? ((sqres_q >> 1) + sqbit_q) : (sqres_q >> 1);
	assign root_nx  = (sqres_nx[63:ROOT_BITS] != '0) ? '1 : sqres_nx[ROOT_BITS-1:0];

	assign mlim = neg ? MEAN_BITS'(1 << (MEAN_BITS - 1)) : MEAN_BITS'((1 << (MEAN_BITS - 1)) - 1);
	assign m    = ((div_q[DIVA_BITS-1:MEAN_BITS] != '0) || (div_q[MEAN_BITS-1:0] > mlim))
		? mlim : div_q[MEAN_BITS-1:0];
	assign dev  = ((div_q[DIVA_BITS-1:ACC_BITS] != '0) || (div_q[ACC_BITS-1:0] > sq_q))
		? '0 : (sq_q - div_q[ACC_BITS-1:0]);
	assign var_nx = (div_q[DIVA_BITS-1:VAR_BITS] != '0) ? '1 : div_q[VAR_BITS-1:0];

	always_comb begin
		if (tot_q == '0)      status = ST_EMPTY;
		else if (sat_q)       status = ST_SAT;
		else if (tot_q == 48'd1) status = ST_ONE;
		else                  status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			tot_q       <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			min_q       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			max_q       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			sat_q       <= 1'b0;
			div_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							K_CLEAR: begin
								tot_q <= '0;
								sum_q <= '0;
								sq_q  <= '0;
								min_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
								max_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
								sat_q <= 1'b0;
							end
							K_SAMPLE: begin
								x_q <= sx;
								w_q <= s_tdata[31:16];
								if ($signed(sx) < $signed(min_q)) min_q <= sx;
								if ($signed(sx) > $signed(max_q)) max_q <= sx;
								state_q <= S_XW;
							end
							K_REPORT: begin
								mean_q <= '0;
								var_q  <= '0;
								sd_q   <= '0;
								se_q   <= '0;
								if (tot_q == '0) begin
									state_q <= DONE;
								end else begin
									div_a_q <= {{(DIVA_BITS-ACC_BITS-FRAC_BITS){1'b0}}, mag,
										{FRAC_BITS{1'b0}}};
									div_d_q     <= {16'd0, tot_q};
									div_start_q <= 1'b1;
									state_q     <= R_MEAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_XW: begin
					p_q     <= prod[32:0];
					state_q <= S_XX;
				end
				S_XX: begin
					xx_q    <= prod[31:0];
					state_q <= S_XXW;
				end
				S_XXW: begin
					p2_q    <= prod[47:0];
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (t49[TOTAL_BITS]) begin
						tot_q <= '1;
						sat_q <= 1'b1;
					end else begin
						tot_q <= t49[TOTAL_BITS-1:0];
					end
					if (!s66[65] && (s66[64:63] != 2'b00)) begin
						sum_q <= {1'b0, {63{1'b1}}};
						sat_q <= 1'b1;
					end else if (s66[65] && (s66[64:63] != 2'b11)) begin
						sum_q <= {1'b1, 63'd0};
						sat_q <= 1'b1;
					end else begin
						sum_q <= s66[63:0];
					end
					if (t65[64]) begin
						sq_q  <= '1;
						sat_q <= 1'b1;
					end else begin
						sq_q <= t65[63:0];
					end
					state_q <= IDLE;
				end
				R_MEAN: begin
					if (div_done) begin
						mean_q <= neg ? (MEAN_BITS'(0) - m) : m;
						acc_q  <= '0;
						k_q    <= 2'd0;
						state_q <= (tot_q == 48'd1) ? DONE : R_MUL;
					end
				end
				R_MUL: begin
					acc_q <= acc_nx;
					k_q   <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						div_a_q     <= acc_nx;
						div_d_q     <= {16'd0, tot_q};
						div_start_q <= 1'b1;
						state_q     <= R_CDIV;
					end
				end
				R_CDIV: begin
					if (div_done) begin
						div_a_q <= {{(DIVA_BITS-ACC_BITS-FRAC_BITS){1'b0}}, dev,
							{FRAC_BITS{1'b0}}};
						div_d_q     <= {16'd0, tot_q - 48'd1};
						div_start_q <= 1'b1;
						state_q     <= R_VDIV;
					end
				end
				R_VDIV: begin
					if (div_done) begin
						var_q   <= var_nx;
						sqv_q   <= {{(ACC_BITS-VAR_BITS-FRAC_BITS){1'b0}}, var_nx,
							{FRAC_BITS{1'b0}}};
						sqres_q <= '0;
						sqbit_q <= 64'd1 << 62;
						state_q <= R_SD;
					end
				end
				R_SD: begin
					if (sqge) sqv_q <= sqv_q - sqt;
					sqres_q <= sqres_nx;
					sqbit_q <= sqbit_q >> 2;
					if (sqbit_q[0]) begin
						sd_q <= root_nx;
						div_a_q <= {{(DIVA_BITS-VAR_BITS-FRAC_BITS){1'b0}}, var_q,
							{FRAC_BITS{1'b0}}};
						div_d_q     <= {16'd0, tot_q};
						div_start_q <= 1'b1;
						state_q     <= R_EDIV;
					end
				end
				R_EDIV: begin
					if (div_done) begin
						sqv_q   <= div_q[ACC_BITS-1:0];
						sqres_q <= '0;
						sqbit_q <= 64'd1 << 62;
						state_q <= R_SE;
					end
				end
				R_SE: begin
					if (sqge) sqv_q <= sqv_q - sqt;
					sqres_q <= sqres_nx;
					sqbit_q <= sqbit_q >> 2;
					if (sqbit_q[0]) begin
						se_q    <= root_nx;
						state_q <= DONE;
					end
				end
				DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status;
						m_tdata_q  <= {se_q, sd_q, var_q, mean_q, max_q, min_q, tot_q};
						state_q    <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == R_MEAN || state_q == R_CDIV || state_q == R_VDIV ||
			state_q == R_EDIV))
		else $error("divider finished outside a wait state");
	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(tot_q == '0 && !sat_q) |-> (sum_q == '0 && sq_q == '0))
		else $error("sums nonzero with no weight");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> !s_tready)
		else $error("input accepted while busy");
	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[191:80] == '0))
		else $error("empty report with nonzero statistics");
endmodule

[sim/testbench.sv]
// Self-checking testbench for weighted_moments_accumulator_core.
// Drives clear, sample and report transactions, predicts each report and
// compares it field by field. Depends on wma_pkg and the core RTL.
module testbench import wma_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] K_IGNORED = 2'd3;
	localparam int IDLE_LIMIT = 6000;
	localparam int RANDOM_ITEMS = 480;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] total_weight;
		logic [15:0] minimum;
		logic [15:0] maximum;
		logic [23:0] mean;
		logic [39:0] variance;
		logic [23:0] std_dev;
		logic [23:0] std_err;
	} stats_t;

	class moments_scoreboard;
		logic [47:0]        weight_sum;
		logic signed [63:0] value_sum;
		logic [63:0]        square_sum;
		logic signed [15:0] lowest;
		logic signed [15:0] highest;
		bit                 clamped;
		stats_t             pending_reports[$];
		int                 errors;

		function void clear_moments();
			weight_sum = '0;
			value_sum = '0;
			square_sum = '0;
			lowest = 16'sh7fff;
			highest = -16'sh8000;
			clamped = 0;
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] bitv;
			root = '0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= root + bitv) begin
					v = v - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		endfunction

		function void note_input(logic [1:0] kind, logic [15:0] sample, logic [15:0] weight);
			logic signed [65:0]  x;
			logic signed [65:0]  prod;
			logic signed [65:0]  next_sum;
			logic [65:0]         next_sq;
			logic [48:0]         next_w;
			logic [63:0]         mag;
			logic [127:0]        quot;
			logic [127:0]        dev;
			logic [63:0]         m;
			logic [63:0]         var_q;
			logic [63:0]         root;
			stats_t              r;
			case (kind)
				K_CLEAR: clear_moments();
				K_SAMPLE: begin
					x = $signed(sample);
					prod = x * $signed({50'd0, weight});
					next_w = {1'b0, weight_sum} + weight;
					if (next_w[48]) begin
						weight_sum = '1;
						clamped = 1;
					end else begin
						weight_sum = next_w[47:0];
					end
					next_sum = $signed(value_sum) + prod;
					if (next_sum > 66'sh0_7fff_ffff_ffff_ffff) begin
						value_sum = 64'sh7fff_ffff_ffff_ffff;
						clamped = 1;
					end else if (next_sum < -66'sh0_8000_0000_0000_0000) begin
						value_sum = 64'sh8000_0000_0000_0000;
						clamped = 1;
					end else begin
						value_sum = next_sum[63:0];
					end
					next_sq = {2'b0, square_sum} + 66'(x * x * $signed({50'd0, weight}));
					if (next_sq[65:64] != 0) begin
						square_sum = '1;
						clamped = 1;
					end else begin
						square_sum = next_sq[63:0];
					end
					if ($signed(sample) < lowest) lowest = sample;
					if ($signed(sample) > highest) highest = sample;
				end
				K_REPORT: begin
					r = '0;
					r.total_weight = weight_sum;
					r.minimum = lowest;
					r.maximum = highest;
					if (weight_sum == 0) r.status = ST_EMPTY;
					else if (clamped) r.status = ST_SAT;
					else if (weight_sum == 1) r.status = ST_ONE;
					else r.status = ST_OK;
					if (weight_sum != 0) begin
						mag = value_sum[63] ? 64'd0 - value_sum : value_sum;
						quot = ({64'd0, mag} << FRAC_BITS) / weight_sum;
						if (value_sum[63]) m = (quot > 128'h80_0000) ? 64'h80_0000 : quot[63:0];
						else m = (quot > 128'h7f_ffff) ? 64'h7f_ffff : quot[63:0];
						r.mean = value_sum[63] ? 24'(64'd0 - m) : m[23:0];
						if (weight_sum != 1) begin
							quot = ({64'd0, mag} * {64'd0, mag}) / weight_sum;
							dev = (quot > square_sum) ? 128'd0 : square_sum - quot;
							quot = (dev << FRAC_BITS) / (weight_sum - 48'd1);
							var_q = (quot > 128'hff_ffff_ffff) ? 64'hff_ffff_ffff : quot[63:0];
							r.variance = var_q[39:0];
							root = int_sqrt(var_q << FRAC_BITS);
							r.std_dev = (root > 64'hff_ffff) ? 24'hff_ffff : root[23:0];
							root = int_sqrt((var_q << FRAC_BITS) / weight_sum);
							r.std_err = (root > 64'hff_ffff) ? 24'hff_ffff : root[23:0];
						end
					end
					pending_reports.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(stats_t got);
			stats_t want;
			if (pending_reports.size() == 0) begin
				mismatch("unexpected report", got.total_weight, 64'd0);
				return;
			end
			want = pending_reports.pop_front();
			if (got.status != want.status) mismatch("status", got.status, want.status);
			if (got.total_weight != want.total_weight)
				mismatch("total_weight", got.total_weight, want.total_weight);
			if (got.minimum != want.minimum) mismatch("minimum", got.minimum, want.minimum);
			if (got.maximum != want.maximum) mismatch("maximum", got.maximum, want.maximum);
			if (got.mean != want.mean) mismatch("mean", got.mean, want.mean);
			if (got.variance != want.variance) mismatch("variance", got.variance, want.variance);
			if (got.std_dev != want.std_dev) mismatch("std_dev", got.std_dev, want.std_dev);
			if (got.std_err != want.std_err) mismatch("std_err", got.std_err, want.std_err);
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic [1:0]   m_tuser;

	moments_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	weighted_moments_accumulator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		stats_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.total_weight = m_tdata[47:0];
			got.minimum = m_tdata[63:48];
			got.maximum = m_tdata[79:64];
			got.mean = m_tdata[103:80];
			got.variance = m_tdata[143:104];
			got.std_dev = m_tdata[167:144];
			got.std_err = m_tdata[191:168];
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) quiet_cycles <= 0;
		else if (arst_n) quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired at %0t", $realtime);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] kind, logic [15:0] sample, logic [15:0] weight);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {weight, sample};
		do @(posedge clk); while (!s_tready);
		sb.note_input(kind, sample, weight);
	endtask

	task automatic send_random();
		int pick;
		logic [15:0] sample;
		logic [15:0] weight;
		pick = $urandom_range(99);
		sample = 16'($urandom);
		weight = 16'($urandom);
		if ($urandom_range(1)) sample = 16'($signed($urandom_range(80)) - 40);
		if ($urandom_range(2) != 0) weight = 16'($urandom_range(4));
		if (pick < 2) send_item(K_CLEAR, 16'($urandom), 16'($urandom));
		else if (pick < 4) send_item(K_IGNORED, 16'($urandom), 16'($urandom));
		else if (pick < 16) send_item(K_REPORT, 16'($urandom), 16'($urandom));
		else send_item(K_SAMPLE, sample, weight);
	endtask

	initial begin
		sb.clear_moments();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(K_REPORT, 16'h0, 16'h0);
		send_item(K_SAMPLE, 16'h7fff, 16'd1);
		send_item(K_REPORT, 16'hffff, 16'hffff);
		send_item(K_SAMPLE, 16'h8000, 16'hffff);
		send_item(K_SAMPLE, 16'h1234, 16'h0);
		send_item(K_REPORT, 16'h0, 16'h0);
		send_item(K_IGNORED, 16'hffff, 16'hffff);
		send_item(K_REPORT, 16'h0, 16'h0);
		send_item(K_CLEAR, 16'hffff, 16'hffff);
		send_item(K_REPORT, 16'h0, 16'h0);
		send_item(K_SAMPLE, 16'h0005, 16'h0);
		send_item(K_REPORT, 16'h0, 16'h0);
		send_item(K_SAMPLE, 16'hffff, 16'hffff);
		send_item(K_SAMPLE, 16'h0001, 16'd2);
		send_item(K_SAMPLE, 16'h7fff, 16'hffff);
		send_item(K_REPORT, 16'h0, 16'h0);
		send_item(K_CLEAR, 16'h0, 16'h0);
		send_item(K_SAMPLE, 16'hfff0, 16'd3);
		send_item(K_SAMPLE, 16'hfff0, 16'd3);
		send_item(K_REPORT, 16'h0, 16'h0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i * 4 / RANDOM_ITEMS)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			send_random();
		end
		s_tvalid <= 1'b0;

		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule

[filelist.f]
design/wma_pkg.sv
design/wma_div.sv
design/weighted_moments_accumulator_core.sv
sim/testbench.sv
